[rtl/core/cpst_pkg.sv]
// Package for the contact push/slide thrust and roll controller.
// Holds constants, mode codes, config indexes and the CORDIC arctangent table.
// No dependencies.
package cpst_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_THRUST    = 3'd0,
        CFG_PUSH_STEP      = 3'd1,
        CFG_THRUST_CEILING = 3'd2,
        CFG_ROLL_LIMIT     = 3'd3,
        CFG_CONTACT_LEVEL  = 3'd4,
        CFG_SLIDE_LEVEL    = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_FREE      = 3'd0,
        MODE_STOP_SLIDE = 3'd1,
        MODE_PUSH      = 3'd2,
        MODE_SLIDE     = 3'd3,
        MODE_HOLD      = 3'd4
    } t_mode;

    localparam logic [20:0] BASE_THRUST_RST    = 21'd1014628;
    localparam logic [15:0] PUSH_STEP_RST      = 16'd1311;
    localparam logic [20:0] THRUST_CEILING_RST = 21'd1081344;
    localparam logic [16:0] ROLL_LIMIT_RST     = 17'd3431;
    localparam logic [18:0] CONTACT_LEVEL_RST  = 19'd9830;
    localparam logic [18:0] SLIDE_LEVEL_RST    = 19'd26214;

    // arctan(2^-i) in Q30
    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        logic [30:0] v;
        case (i)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388438;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097150;
            5'd31: v = 31'd0;
            default: v = 31'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

[rtl/core/contact_push_slide_thrust_roll_control_core.sv]
// Contact push/slide controller: one command pair per control tick.
// Free and push ticks pass through decide, apply and output states; hold ticks
// skip apply. A slide tick runs a serial multiply and a restoring divider;
// slide entry with a nonzero lateral force adds an iterative CORDIC atan2.
// One transaction at a time: input stalls until the result is taken.
// Synchronous active-low reset clears the control state and restores config reset values.
module contact_push_slide_thrust_roll_control_core #(
    parameter int FRAC_BITS    = cpst_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cpst_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [cpst_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cpst_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [21:0] i_lateral_force,
    input  logic signed [21:0] i_vertical_force,
    input  logic signed [21:0] i_roll_torque,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [17:0] o_roll_command,
    output logic [20:0] o_thrust_command,
    output logic [2:0]  o_mode
);
    import cpst_pkg::*;

    localparam int SH = 30 - FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_CORDIC, S_MUL, S_DIV, S_APPLY, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [20:0] r_base, r_ceil;
    logic [15:0] r_step;
    logic [16:0] r_rlim;
    logic [18:0] r_cl, r_sl;

    // controller state
    logic [21:0] r_target, r_issued_t;
    logic signed [17:0] r_issued_r;
    logic        r_sliding;
    logic [16:0] r_angle;

    // captured transaction
    logic [21:0] r_ay, r_az;
    logic        r_neg;

    // CORDIC
    logic signed [47:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [4:0]  r_ci;

    // serial multiply / divide
    logic [35:0] r_prod;
    logic [16:0] r_mcand;
    logic [4:0]  r_mcnt;
    logic [35:0] r_quo;
    logic [21:0] r_rem;
    logic [5:0]  r_dcnt;

    // pending apply inputs
    logic signed [23:0] r_thr_in;
    logic signed [37:0] r_roll_in;
    logic [2:0]  r_mode;

    logic        r_ovalid;
    logic signed [17:0] r_oroll;
    logic [20:0] r_othr;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_roll_command = r_oroll;
    assign o_thrust_command = r_othr;
    assign o_mode = r_mode;

    // CORDIC step
    logic signed [47:0] c_dx, c_dy;
    logic [30:0] c_at;
    logic [4:0]  c_shift;
    assign c_shift = r_ci;
    assign c_dx = r_cx >>> c_shift;
    assign c_dy = r_cy >>> c_shift;
    assign c_at = atan_q30(r_ci);

    // angle rounding
    logic signed [34:0] a_round;
    logic [34:0] a_sh;
    logic [16:0] a_fin;
    always_comb begin
        a_round = 35'(r_cz) + (35'sd1 <<< (SH - 1));
        a_sh = a_round[34] ? 35'd0 : 35'(a_round >>> SH);
        a_fin = (r_cz < 0) ? 17'd0 : ((a_sh > 35'd131071) ? 17'd131071 : a_sh[16:0]);
    end

    // divider step (remainder stays below |fz| < 2^22)
    logic [22:0] d_trial;
    logic [23:0] d_sub;
    assign d_trial = {r_rem, r_quo[35]};
    assign d_sub = {1'b0, d_trial} - {2'b0, r_az};

    // slide thrust decrement: (az - sl)/10 truncated toward zero
    logic signed [22:0] s_diff;
    logic [21:0] s_mag, s_q;
    logic [44:0] s_mul;
    logic signed [23:0] s_d;
    always_comb begin
        s_diff = $signed({1'b0, r_az}) - $signed({4'b0, r_sl});
        s_mag = s_diff[22] ? 22'(-s_diff) : s_diff[21:0];
        s_mul = 45'(s_mag) * 45'd3355444; // ceil(2^25/10)
        s_q = {2'b0, s_mul[44:25]};
        s_d = s_diff[22] ? -$signed({2'b0, s_q}) : $signed({2'b0, s_q});
    end

    // saturation of pending commands
    logic signed [23:0] floor_t;
    logic signed [23:0] t_sat;
    logic signed [37:0] r_sat;
    always_comb begin
        floor_t = $signed({3'b0, r_base}) - $signed({8'b0, r_step});
        if (r_thr_in >= $signed({3'b0, r_ceil})) t_sat = $signed({3'b0, r_ceil});
        else if (r_thr_in <= floor_t) t_sat = floor_t;
        else t_sat = r_thr_in;
        if (t_sat < 0) t_sat = '0;
        if (r_roll_in > $signed({21'b0, r_rlim})) r_sat = $signed({21'b0, r_rlim});
        else if (r_roll_in < -$signed({21'b0, r_rlim})) r_sat = -$signed({21'b0, r_rlim});
        else r_sat = r_roll_in;
    end

    logic [22:0] p_sum;
    assign p_sum = {1'b0, r_target} + {7'b0, r_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= BASE_THRUST_RST;  r_step <= PUSH_STEP_RST;
            r_ceil <= THRUST_CEILING_RST; r_rlim <= ROLL_LIMIT_RST;
            r_cl <= CONTACT_LEVEL_RST;  r_sl <= SLIDE_LEVEL_RST;
            r_target <= '0; r_issued_t <= '0; r_issued_r <= '0;
            r_sliding <= 1'b0; r_angle <= '0;
            r_ovalid <= 1'b0; r_mode <= MODE_FREE;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BASE_THRUST:    r_base <= i_cfg_data;
                    CFG_PUSH_STEP:      r_step <= i_cfg_data[15:0];
                    CFG_THRUST_CEILING: r_ceil <= i_cfg_data;
                    CFG_ROLL_LIMIT:     r_rlim <= i_cfg_data[16:0];
                    CFG_CONTACT_LEVEL:  r_cl <= i_cfg_data[18:0];
                    CFG_SLIDE_LEVEL:    r_sl <= i_cfg_data[18:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ay <= i_lateral_force[21] ? 22'(-i_lateral_force) : i_lateral_force;
                        r_az <= i_vertical_force[21] ? 22'(-i_vertical_force) : i_vertical_force;
                        r_neg <= (i_roll_torque > 0);
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_az < {3'b0, r_cl}) begin
                        r_target <= {1'b0, r_base};
                        r_roll_in <= '0;
                        r_thr_in <= r_sliding ?
                            $signed({3'b0, r_base}) - $signed({8'b0, r_step}) :
                            $signed({3'b0, r_base});
                        r_mode <= r_sliding ? MODE_STOP_SLIDE : MODE_FREE;
                        r_sliding <= 1'b0;
                        r_state <= S_APPLY;
                    end else if (r_az > {3'b0, r_cl} && r_az < {3'b0, r_sl}) begin
                        if (!r_sliding) begin
                            r_target <= p_sum[22] ? 22'h3FFFFF : p_sum[21:0];
                            r_thr_in <= p_sum[22] ? 24'sh3FFFFF : $signed({1'b0, p_sum});
                        end else begin
                            r_thr_in <= $signed({2'b0, r_target});
                        end
                        r_roll_in <= '0;
                        r_mode <= MODE_PUSH;
                        r_state <= S_APPLY;
                    end else if (r_az > {3'b0, r_sl} || r_issued_t == {1'b0, r_ceil}) begin
                        r_mode <= MODE_SLIDE;
                        if (!r_sliding) begin
                            r_issued_t <= r_target;
                            r_cx <= 48'($signed({1'b0, r_az})) <<< 24;
                            r_cy <= 48'($signed({1'b0, r_ay})) <<< 24;
                            r_cz <= '0;
                            r_ci <= '0;
                            r_state <= (r_ay == '0) ? S_MUL : S_CORDIC;
                            if (r_ay == '0) r_angle <= '0;
                        end else begin
                            r_state <= S_MUL;
                        end
                        r_prod <= '0;
                        r_mcnt <= '0;
                    end else begin
                        r_mode <= MODE_HOLD;
                        r_state <= S_OUT;
                    end
                end
                S_CORDIC: begin
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + c_dy; r_cy <= r_cy - c_dx;
                        r_cz <= r_cz + 34'(c_at);
                    end else begin
                        r_cx <= r_cx - c_dy; r_cy <= r_cy + c_dx;
                        r_cz <= r_cz - 34'(c_at);
                    end
                    r_ci <= r_ci + 5'd1;
                    if (32'(r_ci) == CORDIC_STEPS - 1 || r_ci == 5'd31) begin
                        r_state <= S_MUL;
                        r_prod <= '0;
                        r_mcnt <= '0;
                    end
                end
                S_MUL: begin
                    // shift-add, one angle bit per cycle
                    r_mcnt <= r_mcnt + 5'd1;
                    if (r_mcnt == 5'd0) begin
                        // latch angle from CORDIC when freshly computed
                        if (!r_sliding && r_ay != '0) begin
                            r_angle <= a_fin;
                            r_mcand <= a_fin;
                        end else begin
                            r_mcand <= r_sliding ? r_angle : 17'd0;
                        end
                        r_prod <= '0;
                    end else begin
                        r_prod <= {r_prod[34:0], 1'b0} +
                            (r_mcand[16] ? {17'b0, r_sl} : 36'd0);
                        r_mcand <= {r_mcand[15:0], 1'b0};
                        if (r_mcnt == 5'd17) begin
                            r_state <= S_DIV;
                            r_dcnt <= '0;
                            r_thr_in <= $signed({2'b0, r_issued_t}) - s_d;
                        end
                    end
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd0) begin
                        r_quo <= r_prod;
                        r_rem <= '0;
                    end else begin
                        if (!d_sub[23]) r_rem <= d_sub[21:0];
                        else r_rem <= d_trial[21:0];
                        r_quo <= {r_quo[34:0], ~d_sub[23]};
                        if (r_dcnt == 6'd36) begin
                            r_state <= S_APPLY;
                            r_sliding <= 1'b1;
                            // zero vertical force: quotient saturates to the roll limit, or is zero for a zero product
                            if (r_az == '0)
                                r_roll_in <= (r_prod != 36'd0) ?
                                    (r_neg ? -$signed({21'b0, r_rlim}) : $signed({21'b0, r_rlim}))
                                    : '0;
                            else
                                r_roll_in <= r_neg ? -$signed({2'b0, r_quo[34:0], ~d_sub[23]})
                                                   : $signed({2'b0, r_quo[34:0], ~d_sub[23]});
                        end
                    end
                end
                S_APPLY: begin
                    r_issued_t <= t_sat[21:0];
                    r_issued_r <= r_sat[17:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_oroll <= r_issued_r;
                        r_othr <= r_issued_t[20:0];
                    end else if (!i_stall) begin
                        r_ovalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
